### rtl/mdcf_pkg.sv
// Shared types and constants for the marker delimited command framer.
package mdcf_pkg;

   localparam int FRAME_DEPTH = 40;
   localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
   localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FRAME_DEPTH);

   localparam logic [7:0] START_MARKER_RST = 8'h3C;
   localparam logic [7:0] END_MARKER_RST   = 8'h3E;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_BYTE     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_RX    = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] cmd_byte;
      logic       last;
   } rsp_type;

endpackage

### rtl/mdcf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mdcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/marker_delimited_command_framer_core.sv
// Top level: frame assembly and command fetch around a byte frame store RAM.
// A received byte yields no result.
// A fetch with one result (nothing ready, empty, overflow) shows it the next cycle.
// A fetch of an N byte frame passes its first byte through the RAM read and result
// registers, then one per cycle unless stalled, via the RAM read port; input stalls.
// Reset (synchronous): clears flags, fill count and markers ('<', '>'); store kept.
module marker_delimited_command_framer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mdcf_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mdcf_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mdcf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [7:0]                            csr_wdata
);
   import mdcf_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_STREAM
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_count_ff, fill_count_in;
   logic              started_ff, started_in;
   logic              ended_ff, ended_in;
   logic              overflowed_ff, overflowed_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [7:0]        start_marker_ff;
   logic [7:0]        end_marker_ff;

   logic              rsp_free;
   logic              req_accept;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              is_last;

   mdcf_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_count_ff[ADDR_W-1:0]),
      .wr_data (req_data.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || ((req_data.func == FUNC_FETCH) && !rsp_free);
   assign req_accept = req_valid && !req_stall;
   assign is_last    = ((rd_idx_ff + CNT_W'(1)) == len_ff);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      started_in    = started_ff;
      ended_in      = ended_ff;
      overflowed_in = overflowed_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.func == FUNC_RX) begin
                  if (!ended_ff) begin
                     if (req_data.rx_byte == start_marker_ff) begin
                        fill_count_in = '0;
                        started_in    = 1'b1;
                     end else if (req_data.rx_byte == end_marker_ff) begin
                        ended_in = 1'b1;
                     end else if (fill_count_ff < DEPTH_CNT) begin
                        wr_en         = 1'b1;
                        fill_count_in = fill_count_ff + CNT_W'(1);
                     end else begin
                        overflowed_in = 1'b1;
                     end
                  end
               end else if (started_ff && ended_ff) begin
                  started_in    = 1'b0;
                  ended_in      = 1'b0;
                  fill_count_in = '0;
                  if (fill_count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: STATUS_EMPTY, cmd_byte: 8'h00, last: 1'b1};
                  end else begin
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                     rd_idx_in = '0;
                     len_in    = fill_count_ff;
                     state_in  = ST_STREAM;
                  end
               end else if (overflowed_ff) begin
                  started_in    = 1'b0;
                  ended_in      = 1'b0;
                  overflowed_in = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '{status: STATUS_OVERFLOW, cmd_byte: 8'h00, last: 1'b1};
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{status: STATUS_NONE, cmd_byte: 8'h00, last: 1'b1};
               end
            end
         end
         ST_STREAM: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STATUS_BYTE, cmd_byte: rd_data, last: is_last};
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  rd_addr   = rd_idx_in[ADDR_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fill_count_ff   <= '0;
         started_ff      <= 1'b0;
         ended_ff        <= 1'b0;
         overflowed_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         started_ff    <= started_in;
         ended_ff      <= ended_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_START_MARKER: start_marker_ff <= csr_wdata;
               CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      len_ff      <= len_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= DEPTH_CNT)
      else $error("fill count beyond frame depth");

   a_stream_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> (len_ff != '0) && (rd_idx_ff < len_ff))
      else $error("stream index out of frame length");

   a_stream_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) && rsp_valid_ff |-> (rsp_data_ff.status == STATUS_BYTE))
      else $error("non-byte result while streaming");

   a_no_write_in_stream: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE) && !rd_en)
      else $error("store write overlaps a fetch");

   a_stream_done_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> !started_ff && !ended_ff && (fill_count_ff == '0))
      else $error("frame flags not cleared on fetch");

endmodule

### tb/testbench.sv
// Self-checking testbench for the marker delimited command framer core.
`timescale 1ns / 100ps
module testbench;
   import mdcf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_STORE, ACT_FRAME, ACT_EMPTY, ACT_OVER, ACT_IDLE
   } framer_action_type;

   typedef struct packed {
      logic [7:0] start_mk;
      logic [7:0] end_mk;
      logic [6:0] fill;
      logic       started;
      logic       ended;
      logic       over;
   } framer_flags_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_START_MARKER;
   logic [7:0]    csr_wdata = 8'h00;

   // model copy follows accepted transfers, gen copy follows queued stimulus
   framer_flags_type model_flags;
   framer_flags_type gen_flags;
   logic [7:0]       cmd_store [FRAME_DEPTH];

   req_type req_backlog [$];
   rsp_type due_results [$];
   rsp_type want;

   int errors       = 0;
   int planned      = 0;
   int results_seen = 0;
   int gap_left     = 0;
   int burst_left   = 1;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   int mode         = 0;
   int mode_left    = 0;
   int tick         = 0;
   int idle_cycles  = 0;

   marker_delimited_command_framer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic framer_action_type framer_next(inout framer_flags_type f,
                                                     input req_type r, output int pos);
      framer_action_type act;
      act = ACT_NONE;
      pos = int'(f.fill);
      if (r.func == FUNC_RX) begin
         if (!f.ended) begin
            if (r.rx_byte == f.start_mk) begin
               f.fill    = '0;
               f.started = 1'b1;
            end else if (r.rx_byte == f.end_mk) begin
               f.ended = 1'b1;
            end else if (f.fill < FRAME_DEPTH) begin
               act    = ACT_STORE;
               f.fill = f.fill + 7'd1;
            end else begin
               f.over = 1'b1;
            end
         end
      end else if (f.started && f.ended) begin
         act       = (f.fill == 0) ? ACT_EMPTY : ACT_FRAME;
         f.fill    = '0;
         f.started = 1'b0;
         f.ended   = 1'b0;
      end else if (f.over) begin
         act       = ACT_OVER;
         f.started = 1'b0;
         f.ended   = 1'b0;
         f.over    = 1'b0;
      end else begin
         act = ACT_IDLE;
      end
      return act;
   endfunction

   function automatic void predict_fetch_output(req_type r);
      framer_action_type act;
      int                pos;
      rsp_type           res;
      act = framer_next(model_flags, r, pos);
      res = '{status: STATUS_NONE, cmd_byte: 8'h00, last: 1'b1};
      case (act)
         ACT_STORE: cmd_store[pos] = r.rx_byte;
         ACT_FRAME: begin
            for (int i = 0; i < pos; i++) begin
               res.status   = STATUS_BYTE;
               res.cmd_byte = cmd_store[i];
               res.last     = (i == pos - 1);
               due_results.push_back(res);
            end
         end
         ACT_EMPTY: begin
            res.status = STATUS_EMPTY;
            due_results.push_back(res);
         end
         ACT_OVER: begin
            res.status = STATUS_OVERFLOW;
            due_results.push_back(res);
         end
         ACT_IDLE: due_results.push_back(res);
         default: ;
      endcase
   endfunction

   function automatic void queue_item(req_type r);
      int pos;
      void'(framer_next(gen_flags, r, pos));
      req_backlog.push_back(r);
      planned++;
   endfunction

   function automatic void offer_byte(logic [7:0] b);
      req_type r;
      // a bare end marker with no start and no overflow would lock reception for good
      if (b == gen_flags.end_mk && b != gen_flags.start_mk && !gen_flags.started
          && !gen_flags.ended && !gen_flags.over)
         b = gen_flags.start_mk;
      r.func    = FUNC_RX;
      r.rx_byte = b;
      queue_item(r);
   endfunction

   function automatic void offer_fetch();
      req_type r;
      r.func    = FUNC_FETCH;
      r.rx_byte = 8'($urandom_range(0, 255));
      queue_item(r);
   endfunction

   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == gen_flags.start_mk || b == gen_flags.end_mk);
      return b;
   endfunction

   function automatic void offer_frame(int n);
      offer_byte(gen_flags.start_mk);
      repeat (n) offer_byte(payload_byte());
      offer_byte(gen_flags.end_mk);
      offer_fetch();
   endfunction

   task automatic random_traffic(int n_items);
      int stop;
      stop = planned + n_items;
      while (planned < stop) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
               offer_frame(($urandom_range(0, 7) == 0) ? $urandom_range(30, 45)
                                                      : $urandom_range(0, 8));
            6, 7: begin
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 2) == 0) offer_fetch();
                  else offer_byte(8'($urandom_range(0, 255)));
               end
            end
            8: begin
               offer_byte(gen_flags.start_mk);
               repeat ($urandom_range(0, 4)) offer_byte(payload_byte());
               offer_fetch();
            end
            default: offer_byte(gen_flags.end_mk);
         endcase
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_marker(csr_index_type idx, logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_START_MARKER) begin
         model_flags.start_mk = val;
         gen_flags.start_mk   = val;
      end else begin
         model_flags.end_mk = val;
         gen_flags.end_mk   = val;
      end
   endtask

   // sender: bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_fetch_output(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 24)
                                                           : $urandom_range(0, 3);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each transfer, stalls on its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("unexpected result: status %0d cmd_byte 0x%02h last %0b",
                      rsp_data.status, rsp_data.cmd_byte, rsp_data.last);
               errors++;
            end else begin
               want = due_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.cmd_byte !== want.cmd_byte) begin
                  $error("cmd_byte: expected 0x%02h, got 0x%02h",
                         want.cmd_byte, rsp_data.cmd_byte);
                  errors++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  errors++;
               end
            end
            results_seen++;
         end
         tick++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= 15) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (tick % 5 < 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      model_flags = '{start_mk: START_MARKER_RST, end_mk: END_MARKER_RST, default: '0};
      gen_flags   = model_flags;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: idle fetch, stray byte, full-range payload, ignored byte after end,
      // empty frame, fetch before end, restart by a second start marker
      offer_fetch();
      offer_byte(8'h61);
      offer_byte(START_MARKER_RST);
      offer_byte(8'h00);
      offer_byte(8'hFF);
      offer_byte(8'h5A);
      offer_byte(END_MARKER_RST);
      offer_byte(8'h7E);
      offer_fetch();
      offer_byte(START_MARKER_RST);
      offer_byte(END_MARKER_RST);
      offer_fetch();
      offer_byte(START_MARKER_RST);
      offer_byte(8'hAA);
      offer_byte(8'h55);
      offer_fetch();
      offer_byte(END_MARKER_RST);
      offer_fetch();
      offer_byte(START_MARKER_RST);
      offer_byte(8'h78);
      offer_byte(START_MARKER_RST);
      offer_byte(8'h79);
      offer_byte(END_MARKER_RST);
      offer_fetch();
      drain();

      // store overflow without a start, end without start, overflow again on kept count
      repeat (FRAME_DEPTH + 1) offer_byte(payload_byte());
      offer_byte(gen_flags.end_mk);
      offer_byte(payload_byte());
      offer_fetch();
      offer_byte(payload_byte());
      offer_fetch();
      offer_frame(1);
      random_traffic(35);
      drain();

      write_marker(CSR_START_MARKER, 8'h00);
      write_marker(CSR_END_MARKER, 8'hFF);
      random_traffic(25);
      drain();

      write_marker(CSR_START_MARKER, 8'hFF);
      write_marker(CSR_END_MARKER, 8'h00);
      random_traffic(25);
      drain();

      write_marker(CSR_START_MARKER, 8'h55);
      write_marker(CSR_END_MARKER, 8'h55);
      random_traffic(20);
      drain();

      write_marker(CSR_START_MARKER, 8'($urandom_range(0, 255)));
      write_marker(CSR_END_MARKER, 8'($urandom_range(0, 255)));
      random_traffic(25);
      drain();
      repeat (16) @(posedge clock);

      if (errors == 0 && due_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
